### rtl/ftsel_pkg.sv
// Shared types and constants for the fitness rank and truncation select block.
// No dependencies; every other file of the block imports this package.
package ftsel_pkg;

    localparam int FIT_W = 32;
    localparam int GEN_W = 32;
    localparam int ORG_W = 6;
    localparam int PCT_W = 7;

    // Percent saturation point and the reciprocal used for the divide by one hundred.
    // floor(x * 5243 / 2**19) equals floor(x / 100) for every x below 43000.
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
    localparam logic [31:0]      PCT_RECIP = 32'd5243;
    localparam int               PCT_SHIFT = 19;

    // Register byte address of replacement_percent on the configuration port.
    localparam logic [1:0] ADDR_PCT = 2'd0;

    typedef struct packed {
        logic signed [FIT_W-1:0] fitness;
        logic [ORG_W-1:0]        origin;
        logic [GEN_W-1:0]        genotype;
    } rec_t;

    typedef struct packed {
        logic key;
        logic gen;
    } store_we_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL_START,
        ST_SEL_SCAN,
        ST_SWAP_RD,
        ST_SWAP_W1,
        ST_SWAP_W2,
        ST_K_MUL,
        ST_K_DIV,
        ST_TR_RD,
        ST_TR_WR,
        ST_EM_RD,
        ST_EM_OUT
    } ctrl_state_t;

endpackage

### rtl/ftsel_store.sv
// Record store: one write port and two registered read ports over POP records.
// Depends on ftsel_pkg for the record type and the write enable group.
module ftsel_store #(
    parameter int POP = 64,
    parameter int AW  = $clog2(POP)
) (
    input  logic               clk,
    input  ftsel_pkg::store_we_t we,
    input  logic [AW-1:0]      wr_addr,
    input  ftsel_pkg::rec_t    wr_rec,
    input  logic [AW-1:0]      rd_addr_a,
    input  logic [AW-1:0]      rd_addr_b,
    output ftsel_pkg::rec_t    rd_rec_a,
    output ftsel_pkg::rec_t    rd_rec_b
);
    import ftsel_pkg::*;

    logic signed [FIT_W-1:0] fit_mem [POP];
    logic [ORG_W-1:0]        org_mem [POP];
    logic [GEN_W-1:0]        gen_mem [POP];

    rec_t rd_a_reg;
    rec_t rd_b_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we.key)
        begin
            fit_mem[wr_addr] <= wr_rec.fitness;
            org_mem[wr_addr] <= wr_rec.origin;
        end
        if (we.gen)
        begin
            gen_mem[wr_addr] <= wr_rec.genotype;
        end
        rd_a_reg <= '{fitness: fit_mem[rd_addr_a], origin: org_mem[rd_addr_a],
                      genotype: gen_mem[rd_addr_a]};
        rd_b_reg <= '{fitness: fit_mem[rd_addr_b], origin: org_mem[rd_addr_b],
                      genotype: gen_mem[rd_addr_b]};
    end

    assign rd_rec_a = rd_a_reg;
    assign rd_rec_b = rd_b_reg;

endmodule

### rtl/ftsel_ctrl.sv
// Sequencer for loading, selection sort, truncation replacement and result output.
// Depends on ftsel_pkg; drives the ports of ftsel_store.
module ftsel_ctrl #(
    parameter int POP = 64,
    parameter int AW  = $clog2(POP),
    parameter int CW  = $clog2(POP + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ftsel_pkg::FIT_W-1:0] fitness,
    input  logic [ftsel_pkg::GEN_W-1:0]        genotype,
    input  logic                               last_record,
    input  logic [ftsel_pkg::PCT_W-1:0]        pct,
    output ftsel_pkg::store_we_t               we,
    output logic [AW-1:0]                      wr_addr,
    output ftsel_pkg::rec_t                    wr_rec,
    output logic [AW-1:0]                      rd_addr_a,
    output logic [AW-1:0]                      rd_addr_b,
    input  ftsel_pkg::rec_t                    rd_rec_a,
    input  ftsel_pkg::rec_t                    rd_rec_b,
    output logic                               result_valid,
    output logic [5:0]                         rank_position,
    output logic signed [ftsel_pkg::FIT_W-1:0] ranked_fitness,
    output logic [ftsel_pkg::GEN_W-1:0]        ranked_genotype,
    output logic [5:0]                         source_slot,
    output logic                               last_result
);
    import ftsel_pkg::*;

    localparam int PW = PCT_W + CW;

    ctrl_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] m_reg, m_next;
    logic [CW-1:0] k_reg, k_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic signed [FIT_W-1:0] min_reg, min_next;
    logic first_reg, first_next;
    logic pend_reg, pend_next;

    logic [PCT_W-1:0] pct_sat;
    logic [31:0]      kprod;
    logic [CW-1:0]    mirror;
    logic             full;
    logic             last_pos;

    assign pct_sat  = (pct > PCT_SCALE) ? PCT_SCALE : pct;
    assign kprod    = 32'(prod_reg) * PCT_RECIP;
    assign mirror   = count_reg - CW'(1) - i_reg;
    assign full     = (count_reg >= CW'(POP));
    // True when position i is the second to last one, so the sort is complete after it.
    assign last_pos = ((CW + 1)'(i_reg) + (CW + 1)'(2)) >= (CW + 1)'(count_reg);

    assign busy            = (state_reg != ST_IDLE);
    assign rank_position   = 6'(i_reg);
    assign ranked_fitness  = rd_rec_a.fitness;
    assign ranked_genotype = rd_rec_a.genotype;
    assign source_slot     = rd_rec_a.origin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            m_reg     <= '0;
            k_reg     <= '0;
            first_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
            first_reg <= first_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        min_reg  <= min_next;
    end

    always_comb
    begin
        logic [CW-1:0] n_load;

        n_load       = full ? count_reg : count_reg + CW'(1);
        state_next   = state_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        m_next       = m_reg;
        k_next       = k_reg;
        prod_next    = prod_reg;
        min_next     = min_reg;
        first_next   = first_reg;
        pend_next    = pend_reg;
        we           = '{key: 1'b0, gen: 1'b0};
        wr_addr      = i_reg[AW-1:0];
        wr_rec       = rd_rec_a;
        rd_addr_a    = i_reg[AW-1:0];
        rd_addr_b    = m_reg[AW-1:0];
        result_valid = 1'b0;
        last_result  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                wr_addr = count_reg[AW-1:0];
                wr_rec  = '{fitness: fitness, origin: 6'(count_reg), genotype: genotype};
                if (start)
                begin
                    // A record beyond the population size is dropped.
                    if (!full)
                    begin
                        we = '{key: 1'b1, gen: 1'b1};
                    end
                    count_next = n_load;
                    if (last_record)
                    begin
                        i_next     = '0;
                        state_next = (n_load >= CW'(2)) ? ST_SEL_START : ST_K_MUL;
                    end
                end
            end

            ST_SEL_START:
            begin
                j_next     = i_reg + CW'(1);
                m_next     = i_reg;
                pend_next  = 1'b1;
                first_next = 1'b1;
                state_next = ST_SEL_SCAN;
            end

            ST_SEL_SCAN:
            begin
                rd_addr_a = j_reg[AW-1:0];
                // Only a strictly smaller fitness displaces the candidate.
                if (pend_reg && (first_reg || (rd_rec_a.fitness < min_reg)))
                begin
                    min_next   = rd_rec_a.fitness;
                    m_next     = j_reg - CW'(1);
                    first_next = 1'b0;
                end
                if (j_reg < count_reg)
                begin
                    j_next    = j_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (m_reg != i_reg)
                        begin
                            state_next = ST_SWAP_RD;
                        end
                        else if (last_pos)
                        begin
                            state_next = ST_K_MUL;
                        end
                        else
                        begin
                            i_next     = i_reg + CW'(1);
                            state_next = ST_SEL_START;
                        end
                    end
                end
            end

            ST_SWAP_RD:
            begin
                state_next = ST_SWAP_W1;
            end

            ST_SWAP_W1:
            begin
                // Slot i is reread here and returns its old contents for the second write.
                we         = '{key: 1'b1, gen: 1'b1};
                wr_addr    = i_reg[AW-1:0];
                wr_rec     = rd_rec_b;
                state_next = ST_SWAP_W2;
            end

            ST_SWAP_W2:
            begin
                we      = '{key: 1'b1, gen: 1'b1};
                wr_addr = m_reg[AW-1:0];
                wr_rec  = rd_rec_a;
                if (last_pos)
                begin
                    state_next = ST_K_MUL;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SEL_START;
                end
            end

            ST_K_MUL:
            begin
                prod_next  = PW'(pct_sat) * PW'(count_reg);
                state_next = ST_K_DIV;
            end

            ST_K_DIV:
            begin
                k_next     = kprod[PCT_SHIFT +: CW];
                i_next     = '0;
                state_next = ST_TR_RD;
            end

            ST_TR_RD:
            begin
                if (i_reg < k_reg)
                begin
                    rd_addr_a  = mirror[AW-1:0];
                    state_next = ST_TR_WR;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_EM_RD;
                end
            end

            ST_TR_WR:
            begin
                // Only the genotype moves; fitness and origin stay in place.
                we         = '{key: 1'b0, gen: 1'b1};
                wr_addr    = i_reg[AW-1:0];
                i_next     = i_reg + CW'(1);
                state_next = ST_TR_RD;
            end

            ST_EM_RD:
            begin
                state_next = ST_EM_OUT;
            end

            ST_EM_OUT:
            begin
                result_valid = 1'b1;
                last_result  = ((i_reg + CW'(1)) == count_reg);
                if (last_result)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_EM_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/fitness_rank_truncation_select.sv
// Top level of the fitness rank and truncation select block: configuration register,
// record store and sequencer. Depends on ftsel_pkg, ftsel_store and ftsel_ctrl.
//
// The block collects a population of up to POP records, one per start transfer, each a
// signed fitness and a genotype word. Busy stays low while records are loaded, so a
// record can be taken every clock cycle. The record flagged last_record closes the
// population (a flagged record that arrives when POP records are already held is
// dropped but still closes it). Busy then rises and the block selection-sorts the
// records by ascending fitness, taking the first of equal minima at each position. It
// computes k = floor(min(replacement_percent, 100) * n / 100) and, in order for slot
// i = 0 .. k-1, copies the genotype then held in slot n-1-i into slot i. Finally it
// presents one result per slot, weakest first, each for exactly one cycle with
// result_valid high; last_result marks the final slot, after which busy falls and a
// new empty population begins. The receiver cannot stall results, so it must take
// each transfer in the cycle in which it is shown.
//
// Structure: everything runs through one record store with one write port and two
// registered read ports, and one signed comparator. After the last record, the sort
// visits each position i with a scan over slots i .. n-1 plus a swap when the minimum
// lies elsewhere; the percentage takes a multiply and a reciprocal divide, the
// replacement copies k genotypes and the output presents n results.
//
// Configuration: replacement_percent sits at byte address 0 of the APB-style port. It
// resets to 50 and should be written only while busy is low.
module fitness_rank_truncation_select #(
    parameter int POP = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [1:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ftsel_pkg::FIT_W-1:0] fitness,
    input  logic [ftsel_pkg::GEN_W-1:0]        genotype,
    input  logic                               last_record,
    output logic                               result_valid,
    output logic [5:0]                         rank_position,
    output logic signed [ftsel_pkg::FIT_W-1:0] ranked_fitness,
    output logic [ftsel_pkg::GEN_W-1:0]        ranked_genotype,
    output logic [5:0]                         source_slot,
    output logic                               last_result
);
    import ftsel_pkg::*;

    localparam int AW = $clog2(POP);
    localparam int CW = $clog2(POP + 1);

    logic [PCT_W-1:0] pct_reg;
    logic             cfg_write;

    store_we_t     we;
    logic [AW-1:0] wr_addr;
    rec_t          wr_rec;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    rec_t          rd_rec_a;
    rec_t          rd_rec_b;

    // The only register ignores the address, so every write lands in it.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = 32'(pct_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg <= 7'd50;
        end
        else if (cfg_write && (paddr[1:0] == ADDR_PCT || paddr[1:0] != ADDR_PCT))
        begin
            pct_reg <= pwdata[PCT_W-1:0];
        end
    end

    ftsel_store #(
        .POP (POP),
        .AW  (AW)
    ) u_store (
        .clk       (clk),
        .we        (we),
        .wr_addr   (wr_addr),
        .wr_rec    (wr_rec),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_rec_a  (rd_rec_a),
        .rd_rec_b  (rd_rec_b)
    );

    ftsel_ctrl #(
        .POP (POP),
        .AW  (AW),
        .CW  (CW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .fitness         (fitness),
        .genotype        (genotype),
        .last_record     (last_record),
        .pct             (pct_reg),
        .we              (we),
        .wr_addr         (wr_addr),
        .wr_rec          (wr_rec),
        .rd_addr_a       (rd_addr_a),
        .rd_addr_b       (rd_addr_b),
        .rd_rec_a        (rd_rec_a),
        .rd_rec_b        (rd_rec_b),
        .result_valid    (result_valid),
        .rank_position   (rank_position),
        .ranked_fitness  (ranked_fitness),
        .ranked_genotype (ranked_genotype),
        .source_slot     (source_slot),
        .last_result     (last_result)
    );

endmodule

### tb/rank_result_check.sv
`timescale 1ns / 1ps
// Result checker for the fitness rank and truncation select block: it follows the
// configuration and record transfers, ranks each population and compares every slot.
// Depends on ftsel_pkg for the field widths, the record type and the register address.
module rank_result_check #(
    parameter int POP = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [1:0]                         paddr,
    input  logic [31:0]                        pwdata,
    input  logic                               pready,
    input  logic                               start,
    input  logic                               busy,
    input  logic signed [ftsel_pkg::FIT_W-1:0] fitness,
    input  logic [ftsel_pkg::GEN_W-1:0]        genotype,
    input  logic                               last_record,
    input  logic                               result_valid,
    input  logic [5:0]                         rank_position,
    input  logic signed [ftsel_pkg::FIT_W-1:0] ranked_fitness,
    input  logic [ftsel_pkg::GEN_W-1:0]        ranked_genotype,
    input  logic [5:0]                         source_slot,
    input  logic                               last_result,
    output int                                 mismatch_count,
    output int                                 slots_pending
);
    import ftsel_pkg::*;

    localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;

    typedef struct packed {
        logic [5:0]              rank;
        logic signed [FIT_W-1:0] fit;
        logic [GEN_W-1:0]        gen;
        logic [5:0]              src;
        logic                    closing;
    } ranked_slot_t;

    rec_t             population [POP];
    int               held;
    logic [PCT_W-1:0] percent;
    ranked_slot_t     expected_slots [$];
    int               failures = 0;

    // Sorts the held population ascending (first strict minimum wins), overwrites the
    // weakest genotypes with mirrored strongest ones and queues one slot per record.
    function automatic void rank_population();
        rec_t         swap_rec;
        ranked_slot_t slot;
        int           i;
        int           j;
        int           lo;
        int           pct_eff;
        int           mirrored;
        for (i = 0; i < held; i++) begin
            lo = i;
            for (j = i + 1; j < held; j++)
                if ($signed(population[j].fitness) < $signed(population[lo].fitness))
                    lo = j;
            swap_rec       = population[i];
            population[i]  = population[lo];
            population[lo] = swap_rec;
        end
        pct_eff  = (percent > PCT_SCALE) ? int'(PCT_SCALE) : int'(percent);
        mirrored = (pct_eff * held) / int'(PCT_SCALE);
        for (i = 0; i < mirrored; i++)
            population[i].genotype = population[held - 1 - i].genotype;
        for (i = 0; i < held; i++) begin
            slot.rank    = 6'(i);
            slot.fit     = population[i].fitness;
            slot.gen     = population[i].genotype;
            slot.src     = population[i].origin;
            slot.closing = (i == held - 1);
            expected_slots.push_back(slot);
        end
        held = 0;
    endfunction

    task automatic check_slot();
        ranked_slot_t want;
        if (expected_slots.size() == 0) begin
            if (failures < 10)
                $display("unexpected result: rank %0d fit %0d gen %h src %0d last %0b",
                         rank_position, ranked_fitness, ranked_genotype, source_slot,
                         last_result);
            failures++;
        end else begin
            want = expected_slots.pop_front();
            if (rank_position !== want.rank || ranked_fitness !== want.fit ||
                ranked_genotype !== want.gen || source_slot !== want.src ||
                last_result !== want.closing) begin
                if (failures < 10) begin
                    $display("mismatch: expected rank %0d fit %0d gen %h src %0d last %0b",
                             want.rank, $signed(want.fit), want.gen, want.src, want.closing);
                    $display("          actual   rank %0d fit %0d gen %h src %0d last %0b",
                             rank_position, ranked_fitness, ranked_genotype, source_slot,
                             last_result);
                end
                failures++;
            end
        end
    endtask

    // Sampled at the falling edge, where every transfer condition is stable for the
    // rising edge that follows.
    always @(negedge clk) begin
        if (!rst_n) begin
            held    = 0;
            percent = PCT_RESET;
            expected_slots.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_PCT)
                percent = pwdata[PCT_W-1:0];
            if (start && !busy) begin
                if (held < POP) begin
                    population[held].fitness  = fitness;
                    population[held].genotype = genotype;
                    population[held].origin   = 6'(held);
                    held++;
                end
                if (last_record)
                    rank_population();
            end
            if (result_valid)
                check_slot();
        end
        mismatch_count <= failures;
        slots_pending  <= expected_slots.size();
    end

endmodule

### tb/fitness_rank_truncation_select_tb.sv
`timescale 1ns / 1ps
// Testbench top for fitness_rank_truncation_select: clock, reset, record and register
// stimulus, and the verdict. Depends on ftsel_pkg, the block and rank_result_check.
module fitness_rank_truncation_select_tb;
    import ftsel_pkg::*;

    localparam int POP          = 64;
    localparam int PHASE_ITEMS  = 55;
    // The slowest correct run holds the directed populations, the small random ones,
    // two full ones, and a sender that idles in most cycles of one phase. The limit
    // leaves a wide margin above that.
    localparam int CYCLE_LIMIT  = 400000;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [1:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    start;
    logic                    busy;
    logic signed [FIT_W-1:0] fitness;
    logic [GEN_W-1:0]        genotype;
    logic                    last_record;
    logic                    result_valid;
    logic [5:0]              rank_position;
    logic signed [FIT_W-1:0] ranked_fitness;
    logic [GEN_W-1:0]        ranked_genotype;
    logic [5:0]              source_slot;
    logic                    last_result;

    int mismatch_count;
    int slots_pending;
    int cycles = 0;
    int idle_pct = 0;
    int sent_items = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fitness_rank_truncation_select #(
        .POP(POP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .fitness(fitness),
        .genotype(genotype),
        .last_record(last_record),
        .result_valid(result_valid),
        .rank_position(rank_position),
        .ranked_fitness(ranked_fitness),
        .ranked_genotype(ranked_genotype),
        .source_slot(source_slot),
        .last_result(last_result)
    );

    // The checker sits beside the block on the same wires and reports its failure
    // count and the number of ranked slots still owed by the block.
    rank_result_check #(
        .POP(POP)
    ) rank_watch (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .fitness(fitness),
        .genotype(genotype),
        .last_record(last_record),
        .result_valid(result_valid),
        .rank_position(rank_position),
        .ranked_fitness(ranked_fitness),
        .ranked_genotype(ranked_genotype),
        .source_slot(source_slot),
        .last_result(last_result),
        .mismatch_count(mismatch_count),
        .slots_pending(slots_pending)
    );

    // A hung handshake or a block that never finishes a population ends up here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one record and returns at the rising edge that takes the transfer. Each
    // call is entered at a rising edge. Before the offer, start may be held low for a
    // random number of cycles, as the current phase asks. Busy is looked at on the
    // falling edge, where it already holds the value that the next rising edge sees.
    task automatic send_record(input logic signed [FIT_W-1:0] fit,
                               input logic [GEN_W-1:0] gen, input logic closing);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        fitness     <= fit;
        genotype    <= gen;
        last_record <= closing;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sent_items++;
    endtask

    // Waits until every owed slot has arrived and the block has dropped busy, then
    // gives it a few more cycles so that a register write lands on an idle block.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (slots_pending != 0 || busy)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A setup phase, then the access phase held until pready closes the transfer.
    task automatic write_percent(input logic [PCT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PCT;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Fitness values lean toward a narrow band so that equal minima turn up often,
    // and toward the two ends of the signed range.
    function automatic logic signed [FIT_W-1:0] pick_fitness();
        logic signed [FIT_W-1:0] value;
        case ($urandom_range(0, 4))
            0, 1: value = $urandom;
            2, 3: value = $signed(32'($urandom_range(0, 7))) - 32'sd4;
            default: begin
                case ($urandom_range(0, 3))
                    0: value = 32'sh80000000;
                    1: value = 32'sh7fffffff;
                    2: value = 32'sh00000000;
                    default: value = -32'sd1;
                endcase
            end
        endcase
        return value;
    endfunction

    // Settings cover both ends, values above one hundred that must saturate, and
    // anything in between.
    function automatic logic [PCT_W-1:0] pick_percent();
        logic [PCT_W-1:0] value;
        case ($urandom_range(0, 5))
            0: value = 7'd0;
            1: value = 7'd100;
            2: value = 7'd127;
            3: value = 7'($urandom_range(101, 127));
            default: value = 7'($urandom_range(0, 100));
        endcase
        return value;
    endfunction

    task automatic send_population(input int size);
        int r;
        for (r = 0; r < size; r++)
            send_record(pick_fitness(), $urandom, r == size - 1);
    endtask

    initial
    begin
        int phase;
        int size;
        int directed_items;
        bit opening;

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        start       <= 1'b0;
        fitness     <= '0;
        genotype    <= '0;
        last_record <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A population of a single record, under the reset percentage.
        send_record(32'sh7fffffff, 32'hffffffff, 1'b1);

        // Both ends of the fitness range, zero and minus one, with extreme genotypes;
        // half of the four slots take mirrored genotypes.
        send_record(32'sh80000000, 32'h00000000, 1'b0);
        send_record(32'sh7fffffff, 32'hffffffff, 1'b0);
        send_record(32'sh00000000, 32'ha5a5a5a5, 1'b0);
        send_record(-32'sd1,       32'h5a5a5a5a, 1'b1);

        // No replacement at all; three equal fitness values keep their load order.
        drain();
        write_percent(7'd0);
        send_record(32'sd7, 32'h00000001, 1'b0);
        send_record(32'sd7, 32'h00000002, 1'b0);
        send_record(32'sd7, 32'h00000003, 1'b1);

        // Full replacement: past the middle the copies read slots already overwritten.
        drain();
        write_percent(7'd100);
        send_record(32'sd50, 32'h11111111, 1'b0);
        send_record(32'sd40, 32'h22222222, 1'b0);
        send_record(32'sd30, 32'h33333333, 1'b0);
        send_record(32'sd20, 32'h44444444, 1'b0);
        send_record(32'sd10, 32'h55555555, 1'b1);

        // A setting above one hundred saturates; two equal minima, first one wins.
        drain();
        write_percent(7'd127);
        send_record(32'sd3,  32'hdeadbeef, 1'b0);
        send_record(-32'sd8, 32'h01234567, 1'b0);
        send_record(32'sd5,  32'h89abcdef, 1'b0);
        send_record(-32'sd8, 32'hfedcba98, 1'b1);

        // Three quarters of six slots, duplicated most negative value.
        drain();
        write_percent(7'd75);
        send_record(32'sh00000000, 32'h0f0f0f0f, 1'b0);
        send_record(32'sh80000000, 32'hf0f0f0f0, 1'b0);
        send_record(32'sh80000000, 32'h12345678, 1'b0);
        send_record(32'sh7fffffff, 32'h87654321, 1'b0);
        send_record(32'sd1,        32'hcafef00d, 1'b0);
        send_record(-32'sd2,       32'h0badc0de, 1'b1);
        directed_items = sent_items;

        // Random populations in four phases: no sender gaps, gaps in most cycles, no
        // gaps again, and gaps in about a third. The receiver cannot hold results off,
        // so only the sender idles. Phases one and three open with a full population;
        // the first of those runs over, so its closing transfer is a dropped record.
        for (phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 78 : (phase == 3) ? 30 : 0;
            opening  = 1'b1;
            while (sent_items < directed_items + PHASE_ITEMS * (phase + 1)) begin
                if ($urandom_range(0, 2) == 0) begin
                    drain();
                    write_percent(pick_percent());
                end
                if (opening && phase == 0)
                    size = POP + $urandom_range(1, 3);
                else if (opening && phase == 2)
                    size = POP;
                else
                    size = $urandom_range(1, 12);
                send_population(size);
                opening = 1'b0;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && slots_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### fitness_rank_truncation_select.f
rtl/ftsel_pkg.sv
rtl/ftsel_store.sv
rtl/ftsel_ctrl.sv
rtl/fitness_rank_truncation_select.sv
tb/rank_result_check.sv
tb/fitness_rank_truncation_select_tb.sv
